// File: rtl/mlfd_pkg.sv
// mlfd_pkg: shared types and constants of the marker/length frame deframer
// used by every module of the block; depends on nothing
`default_nettype none

package mlfd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned CSR_IDX_W = 8;

   // register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = 8'd1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_TYPE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BAD     = 2'd3;

   typedef enum logic [3:0] {
      PH_HUNT = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_BODY = 4'b0100,
      PH_END  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/marker_length_frame_deframer.sv
// marker_length_frame_deframer: top level, input register, marker registers
// depends on mlfd_pkg, mlfd_parser, mlfd_out_reg
//
//  channel  direction  handshake               payload
//  req_     in         req_tvalid/req_tready   tdata rx_byte, tuser flush
//  rsp_     out        rsp_tvalid/rsp_tready   tdata data, tuser kind
//  csr_     in         csr_valid/csr_ready     csr_index, csr_data
//
// one byte per cycle while the result register is free: a byte waits in
// the input register, is parsed, and a result that it gives lands in the
// result register, from which it goes out on the rsp_ channel.
// reset clears the frame state and both markers.
// a stalled result register stalls the input register, and through it
// req_tready; a byte that gives no result still waits for a free slot.
`default_nettype none

module marker_length_frame_deframer
   import mlfd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [BYTE_W-1:0]    req_tdata,   // [7:0] rx_byte
   input  wire logic                 req_tuser,   // [0] flush
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [BYTE_W-1:0]         rsp_tdata,   // [7:0] data
   output logic [KIND_W-1:0]         rsp_tuser,   // [1:0] kind
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]    csr_data
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_flush_ff;
   logic [BYTE_W-1:0] start_marker_ff, end_marker_ff;
   logic              slot_free, advance;
   result_type        result;

   assign advance     = in_valid_ff && slot_free;
   assign req_tready  = !in_valid_ff || slot_free;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_flush_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= '0;
         end_marker_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_data;
            CSR_END_MARKER:   end_marker_ff   <= csr_data;
            default:          ;
         endcase
      end
   end

   mlfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .rx_byte      (in_byte_ff),
      .flush        (in_flush_ff),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .result       (result)
   );

   mlfd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: rtl/mlfd_parser.sv
// mlfd_parser: frame state machine and byte counter, one byte per cycle while fire is high
// depends on mlfd_pkg
`default_nettype none

module mlfd_parser
   import mlfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire logic              flush,
   input  wire logic [BYTE_W-1:0] start_marker,
   input  wire logic [BYTE_W-1:0] end_marker,
   output result_type             result
);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic              saw_type_ff, saw_type_in;
   logic [BYTE_W-1:0] left_dec;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      saw_type_in   = saw_type_ff;
      result        = '0;
      left_dec      = (bytes_left_ff != '0) ? bytes_left_ff - 1'b1 : bytes_left_ff;
      if (flush) begin
         phase_in      = PH_HUNT;
         bytes_left_in = '0;
         saw_type_in   = 1'b0;
         // a frame whose type byte already went out must be discarded
         if (saw_type_ff && (phase_ff == PH_BODY || phase_ff == PH_END)) begin
            result.valid = 1'b1;
            result.kind  = KIND_BAD;
         end
      end else begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == start_marker) phase_in = PH_LEN;
            end
            PH_LEN: begin
               bytes_left_in = rx_byte;
               saw_type_in   = 1'b0;
               phase_in      = (rx_byte == '0) ? PH_END : PH_BODY;
            end
            PH_BODY: begin
               result.valid  = 1'b1;
               result.kind   = saw_type_ff ? KIND_PAYLOAD : KIND_TYPE;
               result.data   = rx_byte;
               saw_type_in   = 1'b1;
               bytes_left_in = left_dec;
               if (left_dec == '0) phase_in = PH_END;
            end
            PH_END: begin
               result.valid  = 1'b1;
               result.kind   = (saw_type_ff && rx_byte == end_marker) ? KIND_GOOD : KIND_BAD;
               phase_in      = PH_HUNT;
               bytes_left_in = '0;
               saw_type_in   = 1'b0;
            end
            default: begin
               phase_in      = PH_HUNT;
               bytes_left_in = '0;
               saw_type_in   = 1'b0;
            end
         endcase
      end
      if (!fire) result.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         bytes_left_ff <= '0;
         saw_type_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         saw_type_ff   <= saw_type_in;
      end
   end

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      fire && flush |=> phase_ff == PH_HUNT && bytes_left_ff == '0 && !saw_type_ff)
      else $error("flush did not return the parser to hunting");

   a_good_needs_type: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.kind == KIND_GOOD |-> phase_ff == PH_END && saw_type_ff)
      else $error("good end without a type byte");

   a_length_loads: assert property (@(posedge clock) disable iff (reset)
      fire && !flush && phase_ff == PH_LEN && rx_byte != '0
      |=> phase_ff == PH_BODY && bytes_left_ff == $past(rx_byte))
      else $error("length byte not taken into the counter");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> bytes_left_ff != '0)
      else $error("inside a frame body with no bytes left");

endmodule

`default_nettype wire

// File: rtl/mlfd_out_reg.sv
// mlfd_out_reg: result register on the outgoing stream, holds while stalled
// depends on mlfd_pkg
`default_nettype none

module mlfd_out_reg
   import mlfd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire result_type         result,
   output logic                    slot_free,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [BYTE_W-1:0]       rsp_tdata,
   output logic [KIND_W-1:0]       rsp_tuser
);

   logic              valid_ff, valid_in;
   logic [KIND_W-1:0] kind_ff;
   logic [BYTE_W-1:0] data_ff;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) valid_in = advance && result.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (slot_free && advance && result.valid) begin
         kind_ff <= result.kind;
         data_ff <= result.data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for marker_length_frame_deframer
// depends on mlfd_pkg and the deframer rtl; predicts each result from its own frame tracker
`default_nettype none

module testbench;
   import mlfd_pkg::*;

   localparam int QUIET_LIMIT = 5000;   // cycles with no transaction on any channel
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 600;

   typedef struct packed {
      logic              flush;
      logic [BYTE_W-1:0] rx_byte;
   } link_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
   } frame_out_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata = '0;    // [7:0] rx_byte
   logic                 req_tuser = 1'b0;  // [0] flush
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [BYTE_W-1:0]    rsp_tdata;         // [7:0] data
   logic [KIND_W-1:0]    rsp_tuser;         // [1:0] kind
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_data = '0;

   marker_length_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // frame tracker state, mirrors the block
   phase_type         fr_phase = PH_HUNT;
   logic [BYTE_W-1:0] fr_left = '0;
   logic              fr_saw_type = 1'b0;
   logic [BYTE_W-1:0] start_mk = '0;
   logic [BYTE_W-1:0] end_mk = '0;

   link_item_type link_pending[$];
   frame_out_type fr_expected[$];
   int            errors = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // update the frame tracker with one accepted byte, queue the result it gives
   task automatic deframe_byte(input logic fl, input logic [BYTE_W-1:0] b);
      frame_out_type r;
      logic          has_out;
      has_out = 1'b0;
      r = '0;
      if (fl) begin
         has_out = (fr_phase == PH_BODY || fr_phase == PH_END) && fr_saw_type;
         r.kind = KIND_BAD;
         fr_phase = PH_HUNT;
         fr_left = '0;
         fr_saw_type = 1'b0;
      end else begin
         case (fr_phase)
            PH_HUNT: begin
               if (b == start_mk) fr_phase = PH_LEN;
            end
            PH_LEN: begin
               fr_left = b;
               fr_saw_type = 1'b0;
               if (b == 0) fr_phase = PH_END;
               else fr_phase = PH_BODY;
            end
            PH_BODY: begin
               has_out = 1'b1;
               r.kind = fr_saw_type ? KIND_PAYLOAD : KIND_TYPE;
               r.data = b;
               fr_saw_type = 1'b1;
               if (fr_left > 0) fr_left = fr_left - 1'b1;
               if (fr_left == 0) fr_phase = PH_END;
            end
            default: begin
               // zero length frames never saw a type byte, so they end bad
               has_out = 1'b1;
               r.kind = (fr_saw_type && b == end_mk) ? KIND_GOOD : KIND_BAD;
               fr_phase = PH_HUNT;
               fr_left = '0;
               fr_saw_type = 1'b0;
            end
         endcase
      end
      if (has_out) fr_expected = {fr_expected, r};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fr_phase = PH_HUNT;
         fr_left = '0;
         fr_saw_type = 1'b0;
         start_mk = '0;
         end_mk = '0;
      end else if (req_tvalid && req_tready) begin
         deframe_byte(req_tuser, req_tdata);
      end
   end

   // sender: per-item gap, with bursts of back-to-back items
   int            send_gap = 0;
   logic          send_burst = 1'b0;
   link_item_type send_item;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = $urandom_range(0, 17);
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (link_pending.size() > 0) begin
            send_item = link_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= send_item.rx_byte;
            req_tuser <= send_item.flush;
            if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 17);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: per-result stall, one long hold-off once traffic is flowing
   int   rcv_stall = 0;
   logic rcv_burst = 1'b0;
   int   rcv_count = 0;
   int   rcv_hold = 0;
   logic rcv_held = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rcv_stall = $urandom_range(0, 17);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rcv_count++;
            if ($urandom_range(0, 49) == 0) rcv_burst = !rcv_burst;
            rcv_stall = rcv_burst ? 0 : $urandom_range(0, 17);
         end
         if (!rcv_held && rcv_count >= 300) begin
            rcv_held = 1'b1;
            rcv_hold = LONG_HOLD;
         end
         if (rcv_hold > 0) begin
            rcv_hold--;
            rsp_tready <= 1'b0;
         end else if (rcv_stall > 0) begin
            rcv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   frame_out_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fr_expected.size() == 0) begin
            $display("%0t: unexpected result: expected none, got kind %0d data %02h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = fr_expected.pop_front();
            if (rsp_tuser !== want.kind) begin
               $display("%0t: kind mismatch: expected %0d, got %0d",
                        $time, want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== want.data) begin
               $display("%0t: data mismatch: expected %02h, got %02h",
                        $time, want.data, rsp_tdata);
               errors++;
            end
         end
      end
   end

   int quiet = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic link(input logic fl, input logic [BYTE_W-1:0] b);
      link_item_type it;
      it.flush = fl;
      it.rx_byte = b;
      link_pending = {link_pending, it};
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_START_MARKER) start_mk = val;
      else end_mk = val;
   endtask

   // wait until every byte is in and every result is out, then let the pipe empty
   task automatic settle();
      while (link_pending.size() > 0 || req_tvalid || fr_expected.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed frames with random content; some noise, flushes, bad ends
   task automatic queue_traffic(input int n);
      int                pushed;
      int                len;
      int                cut;
      int                i;
      int                pick;
      logic [BYTE_W-1:0] val;
      pushed = 0;
      while (pushed < n) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) link(1'b0, BYTE_W'($urandom_range(0, 255)));
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) len = 0;
         else if (pick == 5) len = $urandom_range(64, 255);
         else len = $urandom_range(1, 8);
         cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len + 2) : -1;
         for (i = 0; i < len + 3; i++) begin
            if (i == cut) begin
               link(1'b1, BYTE_W'($urandom_range(0, 255)));
               pushed++;
               break;
            end
            if (i == 0) val = start_mk;
            else if (i == 1) val = BYTE_W'(len);
            else if (i == len + 2) val = ($urandom_range(0, 99) < 85) ? end_mk
                                                  : BYTE_W'($urandom_range(0, 255));
            else val = BYTE_W'($urandom_range(0, 255));
            link(1'b0, val);
            pushed++;
         end
      end
   endtask

   initial begin
      while (reset) @(posedge clock);
      write_reg(CSR_START_MARKER, 8'hA5);
      write_reg(CSR_END_MARKER, 8'h5A);

      // good frame with extreme bytes and a start marker as payload
      link(1'b0, 8'hA5); link(1'b0, 8'h03); link(1'b0, 8'h00); link(1'b0, 8'hFF);
      link(1'b0, 8'hA5); link(1'b0, 8'h5A);
      // zero length ends bad even with the right end marker
      link(1'b0, 8'hA5); link(1'b0, 8'h00); link(1'b0, 8'h5A);
      // wrong byte at the end position
      link(1'b0, 8'hA5); link(1'b0, 8'h02); link(1'b0, 8'h12); link(1'b0, 8'h34);
      link(1'b0, 8'h00);
      // flush inside the body after the type byte
      link(1'b0, 8'hA5); link(1'b0, 8'h02); link(1'b0, 8'h77); link(1'b1, 8'h00);
      // flush before any type byte, then flush while hunting
      link(1'b0, 8'hA5); link(1'b1, 8'hFF);
      link(1'b1, 8'h00);
      // flush at the end position
      link(1'b0, 8'hA5); link(1'b0, 8'h01); link(1'b0, 8'hC3); link(1'b1, 8'hFF);
      queue_traffic(280);
      settle();

      write_reg(CSR_START_MARKER, 8'h00);
      write_reg(CSR_END_MARKER, 8'hFF);
      queue_traffic(280);
      settle();

      write_reg(CSR_START_MARKER, 8'hFF);
      write_reg(CSR_END_MARKER, 8'h00);
      queue_traffic(280);
      settle();

      // equal markers
      write_reg(CSR_START_MARKER, 8'h7E);
      write_reg(CSR_END_MARKER, 8'h7E);
      queue_traffic(280);
      settle();

      write_reg(CSR_START_MARKER, BYTE_W'($urandom_range(0, 255)));
      write_reg(CSR_END_MARKER, BYTE_W'($urandom_range(0, 255)));
      queue_traffic(280);
      settle();
      repeat (16) @(posedge clock);

      if (errors == 0 && fr_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
rtl/mlfd_pkg.sv
rtl/mlfd_parser.sv
rtl/mlfd_out_reg.sv
rtl/marker_length_frame_deframer.sv
tb/testbench.sv
